### hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Types and constants shared by the configuration registers, the scan
// datapath and the top level.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_REG_W   = 5;
   localparam int CARE_W      = 16;
   localparam int LEN_W       = 6;
   localparam int OFFSET_W    = 32;
   localparam int BYTE_W      = 8;
   localparam int REG_BYTES   = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CARE_MASK    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd3;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low;
      logic [CSR_DATA_W-1:0] pattern_high;
      logic [CARE_W-1:0]     care_mask;
      logic [LEN_REG_W-1:0]  pattern_len;
   } mbps_cfg_type;

   typedef struct packed {
      logic                valid;
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } mbps_result_type;

endpackage

### hdl/masked_byte_pattern_search_unit.sv
// Path: req byte -> input register -> scan compare -> result register -> rsp.
// Throughput: one byte per cycle unless rsp stalls; compare is combinational.
// While a finished result waits on rsp, the input register holds one more byte
// and then req stalls until the result is taken.
// Reset is synchronous and active high; it clears the valid flags, the CSRs,
// the count and the match flag. The window and data registers are not reset.
// ----------------------------------------------------------------------------
// Masked byte pattern search unit
// Scans a byte stream for the first match of a masked pattern in each region
// and reports its start offset, or not found at the end of the region.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_unit
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] data_byte
   input  logic                   req_tuser,  // [0] region_start
   input  logic                   req_tlast,  // region_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // [31:0] match_offset
   output logic                   rsp_tuser,  // [0] found
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   mbps_cfg_type    cfg;
   mbps_result_type scan_res;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [BYTE_W-1:0]   s1_data_ff;
   logic                s1_start_ff;
   logic                s1_last_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_found_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic                out_free;
   logic                scan_fire;
   logic                req_fire;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbps_scan #(
      .PATTERN_MAX (PATTERN_MAX),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .fire         (scan_fire),
      .data_byte    (s1_data_ff),
      .region_start (s1_start_ff),
      .region_last  (s1_last_ff),
      .result       (scan_res)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_fire  = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !scan_fire);
   assign rsp_valid_in = out_free ? (scan_fire && scan_res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
         s1_last_ff  <= req_tlast;
      end
      if (out_free) begin
         rsp_found_ff  <= scan_res.found;
         rsp_offset_ff <= scan_res.match_offset;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

`ifndef NO_ASSERTIONS
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("Not-found result carries a non-zero offset.");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("Input stage lost a byte while the result stage was full.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !s1_valid_ff || scan_fire)
      else $error("Input stage overwritten before its byte was scanned.");

   a_found_valid: assert property (@(posedge clock) disable iff (reset)
      scan_fire && scan_res.found |-> scan_res.valid)
      else $error("Match found without a result.");
`endif

endmodule

### hdl/mbps_csr.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search configuration registers
// Holds the pattern bytes, the care mask and the pattern length.
// ----------------------------------------------------------------------------
module mbps_csr
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output mbps_cfg_type           cfg
);

   mbps_cfg_type cfg_ff;
   mbps_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PATTERN_LOW: begin
               cfg_in.pattern_low = csr_wdata;
            end
            REG_PATTERN_HIGH: begin
               cfg_in.pattern_high = csr_wdata;
            end
            REG_CARE_MASK: begin
               cfg_in.care_mask = csr_wdata[CARE_W-1:0];
            end
            REG_PATTERN_LEN: begin
               cfg_in.pattern_len = csr_wdata[LEN_REG_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/mbps_scan.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search scan datapath
// Keeps the byte window, the region byte count and the match flag, and
// compares the window against the masked pattern combinationally.
// ----------------------------------------------------------------------------
module mbps_scan
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  mbps_cfg_type      cfg,
   input  logic              fire,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              region_start,
   input  logic              region_last,
   output mbps_result_type   result
);

   logic [BYTE_W-1:0]      win_ff    [PATTERN_MAX];
   logic [BYTE_W-1:0]      win_in    [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   done_ff;
   logic                   done_in;

   logic [BYTE_W-1:0]      pat_byte  [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] care_bit;
   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [LEN_W-1:0]       len_c;
   logic [OFFSET_BITS-1:0] count_base;
   logic [OFFSET_BITS-1:0] count_next;
   logic [OFFSET_BITS-1:0] offset_full;
   logic                   done_base;
   logic                   match;
   logic                   hit;

   assign pat_all = {cfg.pattern_high, cfg.pattern_low};

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
      if (j < REG_BYTES) begin : g_reg
         assign pat_byte[j] = pat_all[BYTE_W*j +: BYTE_W];
         assign care_bit[j] = cfg.care_mask[j];
      end else begin : g_wild
         assign pat_byte[j] = '0;
         assign care_bit[j] = 1'b0;
      end
   end

   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   assign len_c = ({1'b0, cfg.pattern_len} > LEN_W'(PATTERN_MAX)) ?
                  LEN_W'(PATTERN_MAX) : {1'b0, cfg.pattern_len};

   assign count_base  = region_start ? '0 : count_ff;
   assign count_next  = (&count_base) ? count_base : count_base + OFFSET_BITS'(1);
   assign done_base   = region_start ? 1'b0 : done_ff;
   assign offset_full = count_next - OFFSET_BITS'(len_c);

   always_comb begin
      logic [BYTE_W-1:0] sel_byte;
      sel_byte = '0;
      match = (len_c != '0) && (count_next >= OFFSET_BITS'(len_c));
      for (int j = 0; j < PATTERN_MAX; j++) begin
         sel_byte = '0;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            if (7'(j) + 7'(k) + 7'd1 == {1'b0, len_c}) begin
               sel_byte = win_in[k];
            end
         end
         if ((7'(j) < {1'b0, len_c}) && care_bit[j] && (sel_byte != pat_byte[j])) begin
            match = 1'b0;
         end
      end
   end

   assign hit = match && !done_base;

   assign result.valid        = hit || (region_last && !done_base);
   assign result.found        = hit;
   assign result.match_offset = hit ? OFFSET_W'(offset_full) : '0;

   assign count_in = region_last ? '0 : count_next;
   assign done_in  = region_last ? 1'b0 : (done_base || hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         win_ff <= win_in;
      end
   end

endmodule
